// File: src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the checker file.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/iutc_pkg.sv
// ============================================================================
// iutc_pkg
// Types, constants and calendar tables for the ISO 8601 UTC to epoch core.
// ============================================================================
package iutc_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int FLD_W   = 7;
    localparam int POS_W   = 5;
    localparam int DAYS_W  = 24;
    localparam int TOD_W   = 17;
    localparam int PROD_W  = 41;
    localparam int EPOCH_W = 32;

    // Error kinds
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FORMAT   = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Calendar constants
    localparam logic [YEAR_W-1:0] YEAR_BASE  = 14'd1970;
    localparam logic [DAYS_W-1:0] LEAPS_BASE = 24'd477;   // leap days through 1969
    localparam logic [FLD_W-1:0]  HOUR_MAX   = 7'd23;
    localparam logic [FLD_W-1:0]  MINSEC_MAX = 7'd59;
    localparam logic [FLD_W-1:0]  MONTH_MAX  = 7'd12;

    // Parsed fields of one timestamp
    typedef struct packed {
        logic              fmt_bad;
        logic [YEAR_W-1:0] year;
        logic [FLD_W-1:0]  month;
        logic [FLD_W-1:0]  day;
        logic [FLD_W-1:0]  hour;
        logic [FLD_W-1:0]  minute;
        logic [FLD_W-1:0]  second;
    } fld_t;

    // Day count and time of day after the calendar stages
    typedef struct packed {
        logic [1:0]        kind;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } cal_t;

    // Days in a month (non-leap), index is month - 1
    function automatic logic [4:0] month_days(input logic [3:0] mi);
        logic [4:0] d;
        unique case (mi)
            4'd1:                      d = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // Days before the first of a month (non-leap), index is month - 1
    function automatic logic [8:0] days_before_month(input logic [3:0] mi);
        logic [8:0] d;
        unique case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: src/iutc_parser.sv
// ============================================================================
// iutc_parser
// Character-level parser: checks separators and digits, accumulates fields,
// and hands the finished field record to the calendar stages.
// ============================================================================
module iutc_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_code,
    input  logic                is_last,
    output logic                out_valid,
    input  logic                out_ready,
    output iutc_pkg::fld_t      fld
);

    typedef enum logic [1:0] {SUF_NONE, SUF_DOT, SUF_OTHER} suffix_t;

    localparam logic [iutc_pkg::POS_W-1:0] POS_SUFFIX = 5'd19;
    localparam logic [iutc_pkg::POS_W-1:0] POS_MAX    = 5'd20;

    logic [iutc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [iutc_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [iutc_pkg::FLD_W-1:0]  month_reg, month_next;
    logic [iutc_pkg::FLD_W-1:0]  day_reg, day_next;
    logic [iutc_pkg::FLD_W-1:0]  hour_reg, hour_next;
    logic [iutc_pkg::FLD_W-1:0]  minute_reg, minute_next;
    logic [iutc_pkg::FLD_W-1:0]  second_reg, second_next;
    logic                        fmt_reg, fmt_next;
    suffix_t                     suffix_reg, suffix_next;

    logic                        out_valid_reg;
    iutc_pkg::fld_t              fld_reg;

    logic                        accept;
    logic                        is_digit;
    logic [3:0]                  digit;
    logic                        fmt_final;

    // Digit decode
    assign is_digit = (char_code >= iutc_pkg::CH_ZERO) && (char_code <= iutc_pkg::CH_NINE);
    assign digit    = char_code[3:0];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign fld       = fld_reg;

    // Per-character field update
    always_comb
    begin
        pos_next    = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : POS_MAX;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        fmt_next    = fmt_reg;
        suffix_next = suffix_reg;
        case (pos_reg) inside
            5'd0, 5'd1, 5'd2, 5'd3:
            begin
                if (is_digit)
                    year_next = (year_reg << 3) + (year_reg << 1) + 14'(digit);
                else
                    fmt_next = 1'b1;
            end
            5'd5, 5'd6:
            begin
                if (is_digit)
                    month_next = (month_reg << 3) + (month_reg << 1) + 7'(digit);
                else
                    fmt_next = 1'b1;
            end
            5'd8, 5'd9:
            begin
                if (is_digit)
                    day_next = (day_reg << 3) + (day_reg << 1) + 7'(digit);
                else
                    fmt_next = 1'b1;
            end
            5'd11, 5'd12:
            begin
                if (is_digit)
                    hour_next = (hour_reg << 3) + (hour_reg << 1) + 7'(digit);
                else
                    fmt_next = 1'b1;
            end
            5'd14, 5'd15:
            begin
                if (is_digit)
                    minute_next = (minute_reg << 3) + (minute_reg << 1) + 7'(digit);
                else
                    fmt_next = 1'b1;
            end
            5'd17, 5'd18:
            begin
                if (is_digit)
                    second_next = (second_reg << 3) + (second_reg << 1) + 7'(digit);
                else
                    fmt_next = 1'b1;
            end
            5'd4, 5'd7:
            begin
                if (char_code != iutc_pkg::CH_DASH)
                    fmt_next = 1'b1;
            end
            5'd10:
            begin
                if (char_code != iutc_pkg::CH_T)
                    fmt_next = 1'b1;
            end
            5'd13, 5'd16:
            begin
                if (char_code != iutc_pkg::CH_COLON)
                    fmt_next = 1'b1;
            end
            POS_SUFFIX:
            begin
                suffix_next = (char_code == iutc_pkg::CH_DOT) ? SUF_DOT : SUF_OTHER;
            end
            default:
            begin
            end
        endcase
    end

    // Length and terminator check on the last character
    always_comb
    begin
        fmt_final = fmt_next;
        if (pos_reg < POS_SUFFIX)
            fmt_final = 1'b1;
        else if (pos_reg == POS_SUFFIX)
        begin
            if (char_code != iutc_pkg::CH_Z)
                fmt_final = 1'b1;
        end
        else if ((char_code != iutc_pkg::CH_Z) || (suffix_next != SUF_DOT))
            fmt_final = 1'b1;
    end

    // Parse state; cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            fmt_reg       <= 1'b0;
            suffix_reg    <= SUF_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                out_valid_reg <= accept && is_last;
            if (accept)
            begin
                if (is_last)
                begin
                    pos_reg    <= '0;
                    year_reg   <= '0;
                    month_reg  <= '0;
                    day_reg    <= '0;
                    hour_reg   <= '0;
                    minute_reg <= '0;
                    second_reg <= '0;
                    fmt_reg    <= 1'b0;
                    suffix_reg <= SUF_NONE;
                end
                else
                begin
                    pos_reg    <= pos_next;
                    year_reg   <= year_next;
                    month_reg  <= month_next;
                    day_reg    <= day_next;
                    hour_reg   <= hour_next;
                    minute_reg <= minute_next;
                    second_reg <= second_next;
                    fmt_reg    <= fmt_next;
                    suffix_reg <= suffix_next;
                end
            end
        end
    end

    // Finished field record
    always_ff @(posedge clk)
    begin
        if (accept && is_last)
        begin
            fld_reg.fmt_bad <= fmt_final;
            fld_reg.year    <= year_next;
            fld_reg.month   <= month_next;
            fld_reg.day     <= day_next;
            fld_reg.hour    <= hour_next;
            fld_reg.minute  <= minute_next;
            fld_reg.second  <= second_next;
        end
    end

endmodule

// File: src/iutc_calendar.sv
// ============================================================================
// iutc_calendar
// Two stages: range checks and division by 100, then leap rule, day-of-month
// check and the closed-form day count since 1970.
// ============================================================================
module iutc_calendar
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  iutc_pkg::fld_t      fld,
    output logic                out_valid,
    input  logic                out_ready,
    output iutc_pkg::cal_t      cal
);

    // Stage B registers
    logic                        b_valid_reg;
    logic                        b_ready;
    logic [1:0]                  b_kind_reg;
    logic [iutc_pkg::YEAR_W-1:0] b_year_reg;
    logic [iutc_pkg::YEAR_W-1:0] b_prev_reg;
    logic [3:0]                  b_mi_reg;
    logic [iutc_pkg::FLD_W-1:0]  b_day_reg;
    logic [7:0]                  b_q100_reg;
    logic [iutc_pkg::TOD_W-1:0]  b_tod_reg;

    // Stage C registers
    logic                        c_valid_reg;
    iutc_pkg::cal_t              c_cal_reg;

    logic                        range_bad;
    logic [iutc_pkg::YEAR_W-1:0] prev_year;
    logic [26:0]                 q100_prod;
    logic [iutc_pkg::TOD_W-1:0]  tod;

    logic [iutc_pkg::YEAR_W-1:0] r100;
    logic                        div100;
    logic                        div400;
    logic                        leap;
    logic [5:0]                  dim;
    logic [1:0]                  kind_c;
    logic [iutc_pkg::DAYS_W-1:0] days;

    assign b_ready   = !b_valid_reg || !c_valid_reg || out_ready;
    assign in_ready  = b_ready;
    assign out_valid = c_valid_reg;
    assign cal       = c_cal_reg;

    // Stage B: range checks, floor((year-1)/100) by reciprocal, time of day
    assign range_bad = (fld.hour > iutc_pkg::HOUR_MAX) || (fld.minute > iutc_pkg::MINSEC_MAX)
                    || (fld.second > iutc_pkg::MINSEC_MAX) || (fld.year < iutc_pkg::YEAR_BASE)
                    || (fld.month == '0) || (fld.month > iutc_pkg::MONTH_MAX)
                    || (fld.day == '0);
    assign prev_year = fld.year - 14'd1;
    assign q100_prod = 27'(prev_year) * 27'd5243;
    assign tod       = 17'(17'(fld.hour) * 17'd3600 + 17'(fld.minute) * 17'd60
                         + 17'(fld.second));

    // Stage C: leap rule from remainder of (year-1)/100, day count
    assign r100   = b_prev_reg - 14'(b_q100_reg) * 14'd100;
    assign div100 = (r100 == 14'd99);
    assign div400 = div100 && (b_q100_reg[1:0] == 2'b11);
    assign leap   = (b_year_reg[1:0] == 2'b00) && (!div100 || div400);
    assign dim    = 6'(iutc_pkg::month_days(b_mi_reg))
                  + 6'((b_mi_reg == 4'd1) && leap);

    always_comb
    begin
        kind_c = b_kind_reg;
        if ((b_kind_reg == iutc_pkg::ERR_NONE) && (7'(dim) < b_day_reg))
            kind_c = iutc_pkg::ERR_RANGE;
    end

    assign days = 24'(24'(b_year_reg - iutc_pkg::YEAR_BASE) * 24'd365)
                + 24'(b_prev_reg >> 2) - 24'(b_q100_reg) + 24'(b_q100_reg >> 2)
                - iutc_pkg::LEAPS_BASE
                + 24'(iutc_pkg::days_before_month(b_mi_reg))
                + 24'((b_mi_reg > 4'd1) && leap)
                + 24'(b_day_reg) - 24'd1;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
                b_valid_reg <= in_valid;
            if (!c_valid_reg || out_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            b_kind_reg <= fld.fmt_bad ? iutc_pkg::ERR_FORMAT
                        : (range_bad ? iutc_pkg::ERR_RANGE : iutc_pkg::ERR_NONE);
            b_year_reg <= fld.year;
            b_prev_reg <= prev_year;
            b_mi_reg   <= 4'(fld.month - 7'd1);
            b_day_reg  <= fld.day;
            b_q100_reg <= q100_prod[26:19];
            b_tod_reg  <= tod;
        end
        if ((!c_valid_reg || out_ready) && b_valid_reg)
        begin
            c_cal_reg.kind <= kind_c;
            c_cal_reg.days <= days;
            c_cal_reg.tod  <= b_tod_reg;
        end
    end

endmodule

// File: src/iutc_epoch.sv
// ============================================================================
// iutc_epoch
// Day count times 86400, then add of time of day, overflow check and the
// result register.
// ============================================================================
module iutc_epoch
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  iutc_pkg::cal_t                cal,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          valid_res,
    output logic [1:0]                    error_kind,
    output logic [iutc_pkg::EPOCH_W-1:0]  epoch_seconds
);

    logic                         d_valid_reg;
    logic                         d_ready;
    logic [1:0]                   d_kind_reg;
    logic [iutc_pkg::PROD_W-1:0]  d_prod_reg;
    logic [iutc_pkg::TOD_W-1:0]   d_tod_reg;

    logic                         e_valid_reg;
    logic                         e_ok_reg;
    logic [1:0]                   e_kind_reg;
    logic [iutc_pkg::EPOCH_W-1:0] e_epoch_reg;

    logic                         e_ready;
    logic [iutc_pkg::PROD_W:0]    sum;
    logic [1:0]                   kind_e;

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;

    assign out_valid     = e_valid_reg;
    assign valid_res     = e_ok_reg;
    assign error_kind    = e_kind_reg;
    assign epoch_seconds = e_epoch_reg;

    // Final add and 32-bit overflow check
    assign sum = 42'(d_prod_reg) + 42'(d_tod_reg);

    always_comb
    begin
        kind_e = d_kind_reg;
        if ((d_kind_reg == iutc_pkg::ERR_NONE) && (|sum[iutc_pkg::PROD_W:iutc_pkg::EPOCH_W]))
            kind_e = iutc_pkg::ERR_OVERFLOW;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
                d_valid_reg <= in_valid;
            if (e_ready)
                e_valid_reg <= d_valid_reg;
        end
    end

    // Multiply stage and result register
    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            d_kind_reg <= cal.kind;
            d_prod_reg <= 41'(cal.days) * 41'd86400;
            d_tod_reg  <= cal.tod;
        end
        if (e_ready && d_valid_reg)
        begin
            e_ok_reg    <= (kind_e == iutc_pkg::ERR_NONE);
            e_kind_reg  <= kind_e;
            e_epoch_reg <= (kind_e == iutc_pkg::ERR_NONE) ? sum[iutc_pkg::EPOCH_W-1:0] : '0;
        end
    end

endmodule

// File: src/iso_utc_timestamp_to_epoch_core.sv
// Result path: after the last character is accepted, its result passes the parse register,
//   two calendar stages, the multiply stage and the result register before it shows on m_tvalid.
// Throughput: one character per cycle while no stall holds the input; each stage holds only
//   while the one after it is full and stalled, so backpressure ripples back from m_tready.
// Reset (rst_n low, asynchronous): parse state and all stage valids clear at once.
// ============================================================================
// iso_utc_timestamp_to_epoch_core
// ISO 8601 UTC timestamp text in, one character per request; Unix epoch
// seconds with valid flag and error kind out, one request per timestamp.
// ============================================================================
module iso_utc_timestamp_to_epoch_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] valid_res, [2:1] error_kind, [34:3] epoch_seconds
);

    iutc_pkg::fld_t               fld;
    iutc_pkg::cal_t               cal;
    logic                         fld_valid;
    logic                         fld_ready;
    logic                         cal_valid;
    logic                         cal_ready;
    logic                         valid_res;
    logic [1:0]                   error_kind;
    logic [iutc_pkg::EPOCH_W-1:0] epoch_seconds;

    iutc_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata),
        .is_last   (s_tlast),
        .out_valid (fld_valid),
        .out_ready (fld_ready),
        .fld       (fld)
    );

    iutc_calendar u_calendar
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fld_valid),
        .in_ready  (fld_ready),
        .fld       (fld),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .cal       (cal)
    );

    iutc_epoch u_epoch
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (cal_valid),
        .in_ready      (cal_ready),
        .cal           (cal),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .valid_res     (valid_res),
        .error_kind    (error_kind),
        .epoch_seconds (epoch_seconds)
    );

    // Result packing, zero padded to whole bytes
    assign m_tdata = {5'b0, epoch_seconds, error_kind, valid_res};

endmodule

// File: src/iutc_checker.sv
// ============================================================================
// iutc_checker
// Port-level checks on the timestamp core, attached by bind.
// ============================================================================
`include "assert_macros.svh"

module iutc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // Stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Input stalls only when a result waits on the output
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

    // Valid flag agrees with error kind
    `ASSERT_IMPLY(a_flag_kind, clk, rst_n, m_tvalid, m_tdata[0] == (m_tdata[2:1] == iutc_pkg::ERR_NONE), "valid flag and error kind disagree")

    // Failed results carry zero seconds
    `ASSERT_IMPLY(a_err_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[34:3] == 32'd0, "nonzero seconds on failed result")

endmodule

bind iso_utc_timestamp_to_epoch_core iutc_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/iso_utc_timestamp_to_epoch_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// iso_utc_timestamp_to_epoch_core_tb
// Streams timestamp text into the core one character per request and checks
// each result against a calendar predictor kept in the scoreboard. Directed
// timestamps cover the epoch limits, leap rules, every range check and the
// format errors. Random timestamps follow, mostly well formed, some corrupted
// and some pure noise. Both sides idle at random, the receiver stalls for a
// long stretch once, and the sender drains the core more than once.
// ============================================================================
module iso_utc_timestamp_to_epoch_core_tb;

    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT   = 3000;
    localparam int END_CYCLES   = 16;
    localparam int RX_HOLD      = 400;
    localparam int TOTAL_CHARS  = 1100;

    // Character at index 19 of the text
    typedef enum logic [1:0] {SFX_NONE, SFX_DOT, SFX_OTHER} sfx_t;

    typedef logic [iutc_pkg::YEAR_W-1:0] year_t;
    typedef logic [iutc_pkg::FLD_W-1:0]  field_t;

    typedef struct {
        logic        ok;
        logic [1:0]  kind;
        logic [31:0] secs;
    } epoch_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parse state, calendar math and the queue of expected results
    // ------------------------------------------------------------------------
    class epoch_scoreboard;
        logic [4:0]         pos;
        year_t              year;
        field_t             month;
        field_t             day;
        field_t             hour;
        field_t             minute;
        field_t             second;
        bit                 bad;
        sfx_t               sfx;
        epoch_result_t      pending[$];
        int                 errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pos    = '0;
            year   = '0;
            month  = '0;
            day    = '0;
            hour   = '0;
            minute = '0;
            second = '0;
            bad    = 1'b0;
            sfx    = SFX_NONE;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // Decimal shift-in; a non-digit flags the text and keeps the value
        function int next_digit(int acc, logic [7:0] c);
            if (c >= iutc_pkg::CH_ZERO && c <= iutc_pkg::CH_NINE)
                return acc * 10 + int'(c - iutc_pkg::CH_ZERO);
            bad = 1'b1;
            return acc;
        endfunction

        function int month_len(int m, bit leap);
            case (m)
                2:             return 28 + int'(leap);
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        function longint unsigned leap_days(longint unsigned n);
            return n / 4 - n / 100 + n / 400;
        endfunction

        // Accepted character; on the last one the expected result is queued
        function void note_char(logic [7:0] c, logic is_last);
            epoch_result_t   r;
            longint unsigned yr;
            longint unsigned days;
            longint unsigned secs;
            bit              leap;
            int              dim;

            case (pos)
                0, 1, 2, 3: year   = year_t'(next_digit(int'(year), c));
                4, 7:       if (c != iutc_pkg::CH_DASH) bad = 1'b1;
                5, 6:       month  = field_t'(next_digit(int'(month), c));
                8, 9:       day    = field_t'(next_digit(int'(day), c));
                10:         if (c != iutc_pkg::CH_T) bad = 1'b1;
                11, 12:     hour   = field_t'(next_digit(int'(hour), c));
                13, 16:     if (c != iutc_pkg::CH_COLON) bad = 1'b1;
                14, 15:     minute = field_t'(next_digit(int'(minute), c));
                17, 18:     second = field_t'(next_digit(int'(second), c));
                19:         sfx = (c == iutc_pkg::CH_DOT) ? SFX_DOT : SFX_OTHER;
                default:    ;
            endcase

            if (!is_last) begin
                if (pos < 5'd20)
                    pos = pos + 5'd1;
                return;
            end

            // Length and terminator
            if (pos < 5'd19)
                bad = 1'b1;
            else if (pos == 5'd19) begin
                if (c != iutc_pkg::CH_Z)
                    bad = 1'b1;
            end
            else if (c != iutc_pkg::CH_Z || sfx != SFX_DOT)
                bad = 1'b1;

            r.ok   = 1'b0;
            r.kind = iutc_pkg::ERR_NONE;
            r.secs = '0;
            if (bad)
                r.kind = iutc_pkg::ERR_FORMAT;
            else if (hour > iutc_pkg::HOUR_MAX || minute > iutc_pkg::MINSEC_MAX ||
                     second > iutc_pkg::MINSEC_MAX || year < iutc_pkg::YEAR_BASE ||
                     month == 0 || month > iutc_pkg::MONTH_MAX || day == 0)
                r.kind = iutc_pkg::ERR_RANGE;
            else begin
                yr   = year;
                leap = (yr % 400 == 0) || (yr % 100 != 0 && yr % 4 == 0);
                dim  = month_len(int'(month), leap);
                if (int'(day) > dim)
                    r.kind = iutc_pkg::ERR_RANGE;
                else begin
                    days = 365 * (yr - 1970) + leap_days(yr - 1) - leap_days(1969)
                         + longint'(day) - 1;
                    for (int m = 1; m < int'(month); m++)
                        days += month_len(m, leap);
                    secs = days * 86400 + longint'(hour) * 3600
                         + longint'(minute) * 60 + longint'(second);
                    if (secs > 64'hFFFF_FFFF)
                        r.kind = iutc_pkg::ERR_OVERFLOW;
                    else begin
                        r.ok   = 1'b1;
                        r.secs = secs[31:0];
                    end
                end
            end
            pending.insert(pending.size(), r);
            clear();
        endfunction

        function void mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            errors++;
        endfunction

        // Accepted result against the oldest expectation
        function void check_result(logic [39:0] data);
            epoch_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none got valid=%0b kind=%0d epoch=%0d",
                         $time, data[0], data[2:1], data[34:3]);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[0] !== want.ok)
                mismatch("valid_res", 32'(want.ok), 32'(data[0]));
            if (data[2:1] !== want.kind)
                mismatch("error_kind", 32'(want.kind), 32'(data[2:1]));
            if (data[34:3] !== want.secs)
                mismatch("epoch_seconds", want.secs, data[34:3]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] char_code
    logic        s_tlast  = 1'b0; // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [0] valid_res, [2:1] error_kind, [34:3] epoch_seconds

    always #4 clk = ~clk;

    iso_utc_timestamp_to_epoch_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    epoch_scoreboard sb;
    logic [7:0]      text[$];
    int              chars_sent = 0;
    int              rx_hold    = 0;
    bit              tx_calm    = 1'b0;
    bit              rx_calm    = 1'b0;
    bit              tx_rush    = 1'b0;

    // Idle count for one request; calm stretches switch idling off for a while
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 9) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    // ------------------------------------------------------------------------
    // Text building
    // ------------------------------------------------------------------------
    function automatic void add_char(logic [7:0] c);
        text.insert(text.size(), c);
    endfunction

    function automatic void put_num(int v, int n);
        logic [7:0] dg[4];
        for (int i = n - 1; i >= 0; i--) begin
            dg[i] = iutc_pkg::CH_ZERO + 8'(v % 10);
            v = v / 10;
        end
        for (int i = 0; i < n; i++)
            add_char(dg[i]);
    endfunction

    function automatic void append_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    // 19-character head YYYY-MM-DDTHH:MM:SS
    function automatic void make_stamp(int y, int mo, int d, int h, int mi, int s);
        text.delete();
        put_num(y, 4);
        add_char(iutc_pkg::CH_DASH);
        put_num(mo, 2);
        add_char(iutc_pkg::CH_DASH);
        put_num(d, 2);
        add_char(iutc_pkg::CH_T);
        put_num(h, 2);
        add_char(iutc_pkg::CH_COLON);
        put_num(mi, 2);
        add_char(iutc_pkg::CH_COLON);
        put_num(s, 2);
    endfunction

    function automatic void append_noise(int n);
        for (int i = 0; i < n; i++)
            add_char(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = tx_rush ? 0 : draw_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_fields(int y, int mo, int d, int h, int mi, int s, string tail);
        make_stamp(y, mo, d, h, mi, s);
        append_str(tail);
        send_text();
    endtask

    // Stop offering until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    // Random timestamp: mostly well formed, some corrupted, some noise
    task automatic send_random_stamp();
        int y, mo, d, h, mi, s, sel, k;
        sel = $urandom_range(0, 99);
        if (sel >= 85) begin
            text.delete();
            append_noise($urandom_range(1, 30));
            if (text.size() > 19 && $urandom_range(0, 1) == 1)
                text[19] = iutc_pkg::CH_DOT;
            if ($urandom_range(0, 1) == 1)
                text[text.size() - 1] = iutc_pkg::CH_Z;
            send_text();
            return;
        end

        y  = ($urandom_range(0, 4) != 0) ? $urandom_range(1970, 2106) : $urandom_range(0, 9999);
        mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        d  = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        h  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 99);
        mi = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 99);
        s  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 99);
        // Leap-day and overflow neighborhoods
        if ($urandom_range(0, 9) == 0) begin
            mo = 2;
            d  = $urandom_range(28, 30);
        end
        else if ($urandom_range(0, 19) == 0) begin
            y  = 2106;
            mo = 2;
            d  = $urandom_range(6, 8);
        end
        make_stamp(y, mo, d, h, mi, s);
        if ($urandom_range(0, 1) == 1) begin
            add_char(iutc_pkg::CH_DOT);
            append_noise($urandom_range(0, 8));
        end
        add_char(iutc_pkg::CH_Z);

        // Broken variants
        if (sel >= 70) begin
            case ($urandom_range(0, 3))
                0: begin
                    k = $urandom_range(0, text.size() - 1);
                    text[k] = 8'($urandom_range(0, 255));
                end
                1: begin
                    k = $urandom_range(1, text.size() - 1);
                    while (text.size() > k)
                        void'(text.pop_back());
                end
                2: text[text.size() - 1] = 8'($urandom_range(0, 255));
                default: begin
                    text.insert(19, 8'($urandom_range(0, 255)));
                    text.insert(19, 8'($urandom_range(0, 255)));
                end
            endcase
        end
        send_text();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random readiness, one long hold on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (rx_hold > 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end
            else
                gap = draw_gap(rx_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Requests accepted on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog on cycles without any accepted request
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("iso_utc_timestamp_to_epoch_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int n;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Epoch limits and overflow
        send_fields(1970, 1, 1, 0, 0, 0, "Z");
        send_fields(2106, 2, 7, 6, 28, 15, "Z");
        send_fields(2106, 2, 7, 6, 28, 16, "Z");
        send_fields(9999, 12, 31, 23, 59, 59, "Z");
        // Leap rules: 400, 100 and 4
        send_fields(2000, 2, 29, 12, 34, 56, "Z");
        send_fields(2100, 2, 29, 0, 0, 0, "Z");
        send_fields(2024, 2, 29, 23, 0, 1, ".5Z");
        send_fields(2023, 2, 29, 1, 2, 3, "Z");
        // Range checks
        send_fields(1969, 12, 31, 23, 59, 59, "Z");
        send_fields(0, 1, 1, 0, 0, 0, "Z");
        send_fields(2024, 0, 10, 0, 0, 0, "Z");
        send_fields(2024, 13, 1, 0, 0, 0, "Z");
        send_fields(2024, 4, 31, 0, 0, 0, "Z");
        send_fields(2024, 1, 0, 0, 0, 0, "Z");
        send_fields(2024, 5, 6, 24, 0, 0, "Z");
        send_fields(2024, 5, 6, 0, 60, 0, "Z");
        send_fields(2024, 5, 6, 0, 0, 60, "Z");
        send_fields(2030, 99, 99, 99, 99, 99, "Z");
        // Fractional forms: empty fraction, long fraction past the saturation point
        send_fields(2024, 6, 15, 8, 30, 45, ".Z");
        make_stamp(2038, 1, 19, 3, 14, 7);
        add_char(iutc_pkg::CH_DOT);
        add_char(8'h00);
        add_char(8'hFF);
        append_noise(36);
        add_char(iutc_pkg::CH_Z);
        send_text();
        // Format errors: long text without dot, fraction not closed by Z, bad terminator
        send_fields(2024, 6, 15, 8, 30, 45, "+0000Z");
        send_fields(2024, 6, 15, 8, 30, 45, ".1234");
        send_fields(2024, 6, 15, 8, 30, 45, "z");
        // Short texts: a lone character and a truncated head
        text.delete();
        add_char(iutc_pkg::CH_Z);
        send_text();
        make_stamp(2024, 6, 15, 8, 30, 45);
        void'(text.pop_back());
        send_text();
        // Non-digit in a digit place, bad separators; format wins over range
        make_stamp(2024, 6, 15, 8, 30, 45);
        text[2] = "A";
        add_char(iutc_pkg::CH_Z);
        send_text();
        make_stamp(1900, 1, 1, 0, 0, 0);
        text[4]  = "/";
        text[10] = " ";
        add_char(iutc_pkg::CH_Z);
        send_text();
        drain();

        // Random part, up to the total character count
        n = 0;
        while (chars_sent < TOTAL_CHARS) begin
            // Long receiver stall while the sender keeps pushing at full rate
            if (n == 5) begin
                rx_hold = RX_HOLD;
                tx_rush = 1'b1;
            end
            if (n == 12)
                tx_rush = 1'b0;
            if (n == 18)
                drain();
            send_random_stamp();
            n++;
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (sb.outstanding() != 0);
        repeat (END_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("iso_utc_timestamp_to_epoch_core: match");
        else
            $display("iso_utc_timestamp_to_epoch_core: mismatch");
        $finish;
    end

endmodule

// File: iso_utc_timestamp_to_epoch_core.f
+incdir+src
src/iutc_pkg.sv
src/iutc_parser.sv
src/iutc_calendar.sv
src/iutc_epoch.sv
src/iso_utc_timestamp_to_epoch_core.sv
src/iutc_checker.sv
test/iso_utc_timestamp_to_epoch_core_tb.sv
